[rtl/pfr_pkg.sv]
// Shared types and constants of the powerline frame receiver.
package pfr_pkg;

  // Receive phase; the fourth code is unused and decodes as hunting
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_CMD  = 2'd2
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_BCAST_ADDR = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned START_W   = 4;
  localparam int unsigned XCNT_W    = 8;

  localparam logic [START_W-1:0] START_PATTERN   = 4'hE;
  localparam logic [CFG_W-1:0]   OWN_ADDR_RST    = 8'd60;
  localparam logic [CFG_W-1:0]   BCAST_ADDR_RST  = 8'd170;
  localparam logic [CFG_W-1:0]   TIMEOUT_RST     = 8'd50;
  localparam logic [XCNT_W-1:0]  XCNT_MAX        = 8'hFF;

  // One result beat
  typedef struct packed {
    logic             command_valid;
    logic [CMD_W-1:0] command;
    logic             ready_res;
  } result_t;

  // Configuration seen by the frame decoder
  typedef struct packed {
    logic [CFG_W-1:0] own_addr;
    logic [CFG_W-1:0] bcast_addr;
    logic [CFG_W-1:0] timeout;
  } cfg_t;

endpackage

[rtl/pfr_frame.sv]
// Frame decoder: start hunt, address and command shift, timeout and match.
module pfr_frame
  import pfr_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 8,
  parameter int unsigned COMMAND_BITS = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    data_bit_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned MAX_BITS = (ADDRESS_BITS > COMMAND_BITS) ? ADDRESS_BITS
                                                                   : COMMAND_BITS;
  localparam int unsigned CNT_W    = $clog2(MAX_BITS + 1);

  phase_e                    phase_q, phase_d;
  logic [START_W-1:0]        start_q, start_d;
  logic [ADDRESS_BITS-1:0]   addr_q, addr_d;
  logic [COMMAND_BITS-1:0]   cmd_q, cmd_d;
  logic [CNT_W-1:0]          bit_cnt_q, bit_cnt_d;
  logic [XCNT_W-1:0]         xcnt_q, xcnt_d;

  logic [START_W-1:0]        start_new;
  logic [ADDRESS_BITS:0]     addr_sh;
  logic [COMMAND_BITS:0]     cmd_sh;
  logic [CNT_W-1:0]          cnt_inc;
  logic [ADDRESS_BITS+CFG_W-1:0] own_ext, bcast_ext;
  logic [COMMAND_BITS+CMD_W-1:0] cmd_ext;
  logic                      addr_match;
  logic                      relisten;

  assign start_new  = {start_q[START_W-2:0], data_bit_i};
  assign addr_sh    = {addr_q, data_bit_i};
  assign cmd_sh     = {cmd_q, data_bit_i};
  assign cnt_inc    = bit_cnt_q + CNT_W'(1);
  // registers masked or zero-extended to the address width
  assign own_ext    = {ADDRESS_BITS'(0), cfg_i.own_addr};
  assign bcast_ext  = {ADDRESS_BITS'(0), cfg_i.bcast_addr};
  assign addr_match = (addr_q == own_ext[ADDRESS_BITS-1:0]) ||
                      (addr_q == bcast_ext[ADDRESS_BITS-1:0]);
  assign cmd_ext    = {CMD_W'(0), cmd_sh[COMMAND_BITS-1:0]};

  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    addr_d    = addr_q;
    cmd_d     = cmd_q;
    bit_cnt_d = bit_cnt_q;
    relisten  = 1'b0;
    res_o     = '0;
    case (phase_q)
      PH_ADDR: begin
        addr_d = addr_sh[ADDRESS_BITS-1:0];
        if (cnt_inc == CNT_W'(ADDRESS_BITS)) begin
          phase_d   = PH_CMD;
          bit_cnt_d = '0;
        end else begin
          bit_cnt_d = cnt_inc;
        end
      end
      PH_CMD: begin
        cmd_d = cmd_sh[COMMAND_BITS-1:0];
        if (cnt_inc == CNT_W'(COMMAND_BITS)) begin
          bit_cnt_d = '0;
          relisten  = 1'b1;
          if (addr_match) begin
            res_o.command_valid = 1'b1;
            res_o.command       = cmd_ext[CMD_W-1:0];
          end
        end else begin
          bit_cnt_d = cnt_inc;
        end
      end
      default: begin
        start_d = start_new;
        if (xcnt_q > cfg_i.timeout) begin
          relisten = 1'b1;
        end else if (start_new == START_PATTERN) begin
          phase_d = PH_ADDR;
        end
      end
    endcase
    if (relisten) begin
      phase_d         = PH_HUNT;
      start_d         = '0;
      addr_d          = '0;
      cmd_d           = '0;
      res_o.ready_res = 1'b1;
    end
  end

  // count restarts at zero and is bumped for this beat
  always_comb begin
    if (relisten) begin
      xcnt_d = XCNT_W'(1);
    end else if (xcnt_q == XCNT_MAX) begin
      xcnt_d = xcnt_q;
    end else begin
      xcnt_d = xcnt_q + XCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      start_q   <= '0;
      addr_q    <= '0;
      cmd_q     <= '0;
      bit_cnt_q <= '0;
      xcnt_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      start_q   <= start_d;
      addr_q    <= addr_d;
      cmd_q     <= cmd_d;
      bit_cnt_q <= bit_cnt_d;
      xcnt_q    <= xcnt_d;
    end
  end

endmodule

[rtl/powerline_frame_receiver.sv]
// Top level of the powerline frame receiver: config registers, decoder and output buffer.
//
// Takes one sampled carrier bit per beat (one per mains zero crossing) and
// returns exactly one result beat for each: command_valid/command when a
// frame addressed to this unit (own or broadcast address) has just ended, and
// ready_res when listening restarts after a frame or a start-hunt timeout.
// A frame is the start pattern 1,1,1,0, then ADDRESS_BITS address bits and
// COMMAND_BITS command bits, first bit received as MSB. The decoder does all
// of one bit's work combinationally; while in_stall_o is low a bit is taken
// every cycle, its result registered in the output buffer. A two-entry output
// buffer (result register plus skid register) sits on the output side, so
// in_stall_o rises only once two results are waiting and comes straight from
// a register. Configuration writes are always ready and must be made while
// the block is idle; there is no clearing pass after reset.
module powerline_frame_receiver
  import pfr_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 8,
  parameter int unsigned COMMAND_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // bit input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 data_bit_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 command_valid_o,
  output logic [CMD_W-1:0]     command_o,
  output logic                 ready_res_o
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    in_accept, out_fire;

  // ---- configuration registers ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr   <= OWN_ADDR_RST;
      cfg_q.bcast_addr <= BCAST_ADDR_RST;
      cfg_q.timeout    <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OWN_ADDR:   cfg_q.own_addr   <= cfg_data_i;
        CFG_BCAST_ADDR: cfg_q.bcast_addr <= cfg_data_i;
        CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---- frame decoder ----
  assign in_accept = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  pfr_frame #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_accept),
    .data_bit_i (data_bit_i),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  // ---- output register with skid entry ----
  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        // skid drains first; input is stalled this cycle
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_accept;
        out_d       = res;
      end
    end else if (in_accept) begin
      // result register held: park the new beat
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign command_valid_o = out_q.command_valid;
  assign command_o       = out_q.command;
  assign ready_res_o     = out_q.ready_res;

  // ---- assertions ----
  // a delivered command always closes the frame
  a_cmd_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_valid_o |-> ready_res_o)
    else $error("command beat without ready_res");

  // command nibble is zero unless flagged valid
  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !command_valid_o |-> command_o == '0)
    else $error("command set without command_valid");

  // skid only fills behind a held result
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // every accepted bit leaves a result behind it
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

[tb/sv/powerline_frame_receiver_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the powerline frame receiver: frame predictor, driving tasks, checks.
module powerline_frame_receiver_tb;
  import pfr_pkg::*;

  // Frame geometry used by both the block and the predictor
  localparam int unsigned ADDR_BITS   = 8;
  localparam int unsigned CMD_BITS    = 4;
  localparam int unsigned FRAME_W     = START_W + ADDR_BITS + CMD_BITS;
  // Long receiver hold-off, long enough to fill the two-entry output buffer
  localparam int unsigned HOLD_CYCLES = 300;
  // Bound on any drain wait
  localparam int unsigned DRAIN_LIMIT = 5000;

  // --------------------------------------------------------------------------
  // Frame predictor and result checker.
  // Tracks the decoder state beat by beat and keeps the results still owed
  // by the block in arrival order.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [CFG_W-1:0]     own_addr;
    logic [CFG_W-1:0]     bcast_addr;
    logic [CFG_W-1:0]     hunt_limit;

    phase_e               ph;
    logic [START_W-1:0]   start_sh;
    logic [ADDR_BITS-1:0] addr_sh;
    logic [CMD_BITS-1:0]  cmd_sh;
    logic [4:0]           bit_cnt;
    logic [XCNT_W-1:0]    xcnt;

    result_t              owed_q[$];

    int unsigned          n_bits;
    int unsigned          n_results;
    int unsigned          n_commands;
    int unsigned          n_frame_ends;
    int unsigned          n_timeouts;
    int unsigned          n_saturated;
    int unsigned          mismatches;

    function new();
      own_addr     = OWN_ADDR_RST;
      bcast_addr   = BCAST_ADDR_RST;
      hunt_limit   = TIMEOUT_RST;
      ph           = PH_HUNT;
      start_sh     = '0;
      addr_sh      = '0;
      cmd_sh       = '0;
      bit_cnt      = '0;
      xcnt         = '0;
      n_bits       = 0;
      n_results    = 0;
      n_commands   = 0;
      n_frame_ends = 0;
      n_timeouts   = 0;
      n_saturated  = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_OWN_ADDR:   own_addr   = val;
        CFG_BCAST_ADDR: bcast_addr = val;
        CFG_TIMEOUT:    hunt_limit = val;
        default: ;
      endcase
    endfunction

    // Restart listening; bit_cnt is left alone on purpose
    function void clear_listening();
      start_sh = '0;
      addr_sh  = '0;
      cmd_sh   = '0;
      ph       = PH_HUNT;
      xcnt     = '0;
    endfunction

    // Accepted input beat: advance the decoder and queue its one result
    function void note_bit(logic b);
      result_t r;
      logic    hunting;
      r       = '0;
      hunting = (ph != PH_ADDR) && (ph != PH_CMD);
      n_bits++;

      if (hunting) begin
        start_sh = {start_sh[START_W-2:0], b};
      end else if (ph == PH_ADDR) begin
        addr_sh = {addr_sh[ADDR_BITS-2:0], b};
        bit_cnt = bit_cnt + 5'd1;
      end else begin
        cmd_sh  = {cmd_sh[CMD_BITS-2:0], b};
        bit_cnt = bit_cnt + 5'd1;
      end

      // hunt timeout judged on the count held before this beat; bit is lost
      if (hunting && xcnt > hunt_limit) begin
        clear_listening();
        r.ready_res = 1'b1;
        n_timeouts++;
      end

      if (hunting) begin
        if (start_sh == START_PATTERN) begin
          ph = PH_ADDR;
        end
      end else if (ph == PH_ADDR) begin
        if (bit_cnt == 5'(ADDR_BITS)) begin
          ph      = PH_CMD;
          bit_cnt = '0;
        end
      end else if (bit_cnt == 5'(CMD_BITS)) begin
        bit_cnt = '0;
        if (addr_sh == own_addr[ADDR_BITS-1:0] || addr_sh == bcast_addr[ADDR_BITS-1:0]) begin
          r.command_valid = 1'b1;
          r.command       = CMD_W'(cmd_sh);
          n_commands++;
        end
        clear_listening();
        r.ready_res = 1'b1;
        n_frame_ends++;
      end

      // crossing count runs in every phase and sticks at its top
      if (xcnt != XCNT_MAX) begin
        xcnt = xcnt + XCNT_W'(1);
      end else begin
        n_saturated++;
      end

      owed_q.push_back(r);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    // Accepted result beat: compare with the oldest owed result
    function void check_result(result_t got);
      result_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        report("result beat with nothing owed", 0, 32'(got));
        return;
      end
      want = owed_q.pop_front();
      if (got.command_valid !== want.command_valid) begin
        report("command_valid", 32'(want.command_valid), 32'(got.command_valid));
      end
      if (got.command !== want.command) begin
        report("command", 32'(want.command), 32'(got.command));
      end
      if (got.ready_res !== want.ready_res) begin
        report("ready_res", 32'(want.ready_res), 32'(got.ready_res));
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 data_bit_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 command_valid_o;
  logic [CMD_W-1:0]     command_o;
  logic                 ready_res_o;

  frame_scoreboard      sb = new();

  // Idling knobs, in percent, and the hold-off request to the receiver
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  bit                   hold_req       = 1'b0;
  int unsigned          bits_sent      = 0;
  int unsigned          settings_used  = 1;

  powerline_frame_receiver #(
    .ADDRESS_BITS(ADDR_BITS),
    .COMMAND_BITS(CMD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_bit_i     (data_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_valid_o(command_valid_o),
    .command_o      (command_o),
    .ready_res_o    (ready_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Run stopped on the time limit");
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: all sampling at the rising edge, before the edge's updates land.
  // The output beat is checked first; an input taken at this edge cannot have
  // produced it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.command_valid = command_valid_o;
        seen.command       = command_o;
        seen.ready_res     = ready_res_o;
        sb.check_result(seen);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_bit(data_bit_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // One bit beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_bit(input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_bit_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bits_sent++;
  endtask

  // First nbits of a frame: start pattern, address then command, MSB first
  task automatic send_frame(input logic [ADDR_BITS-1:0] a, input logic [CMD_BITS-1:0] c,
                            input int unsigned nbits);
    logic [FRAME_W-1:0] fr;
    fr = {START_PATTERN, a, c};
    for (int unsigned i = 0; i < nbits; i++) begin
      send_bit(fr[FRAME_W-1-i]);
    end
  endtask

  // Sender pause: nothing offered until every owed result is back or DRAIN_LIMIT runs out
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Whole register set, back to back; only called with the block idle
  task automatic set_cfg(input logic [CFG_W-1:0] own, input logic [CFG_W-1:0] bcast,
                         input logic [CFG_W-1:0] tmo);
    write_reg(CFG_OWN_ADDR, own);
    write_reg(CFG_BCAST_ADDR, bcast);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed frames with random content, the rest noise, long
  // constant runs (walk the crossing count to timeout and saturation) and
  // frames cut short
  task automatic random_traffic(input int unsigned budget);
    int unsigned          stop_at;
    int unsigned          pick;
    int unsigned          len;
    logic [ADDR_BITS-1:0] a;
    logic                 lvl;
    stop_at = bits_sent + budget;
    while (bits_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        lvl = 1'($urandom_range(1));
        len = $urandom_range(300, 40);
        repeat (len) send_bit(lvl);
      end else if (pick < 20) begin
        len = $urandom_range(12, 1);
        repeat (len) send_bit(1'($urandom_range(1)));
      end else begin
        len = $urandom_range(3);
        repeat (len) send_bit(1'($urandom_range(1)));
        pick = $urandom_range(99);
        if (pick < 40) begin
          a = sb.own_addr[ADDR_BITS-1:0];
        end else if (pick < 70) begin
          a = sb.bcast_addr[ADDR_BITS-1:0];
        end else if (pick < 85) begin
          a = ADDR_BITS'($urandom);
        end else begin
          // near miss: own address with one bit flipped
          a = sb.own_addr[ADDR_BITS-1:0] ^ (ADDR_BITS'(1) << $urandom_range(ADDR_BITS-1));
        end
        // one frame in eight is broken off early
        len = ($urandom_range(7) == 0) ? $urandom_range(FRAME_W-1, 1) : FRAME_W;
        send_frame(a, CMD_BITS'($urandom), len);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] shared_addr;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_OWN_ADDR;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    data_bit_i  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender sparse, receiver mostly stalled
    send_idle_pct  = 32;
    recv_stall_pct = 72;

    // Directed, reset register values: own address with all-ones command,
    // broadcast address with all-zeros command
    send_frame(OWN_ADDR_RST, '1, FRAME_W);
    send_frame(BCAST_ADDR_RST, '0, FRAME_W);
    random_traffic(220);

    // Address extremes and the widest hunt window (reaches saturation)
    drain();
    set_cfg(8'h00, 8'hFF, 8'd254);
    random_traffic(420);

    // Roles swapped: receiver fast, sender sparse
    drain();
    send_idle_pct  = 72;
    recv_stall_pct = 32;
    // Zero hunt window: every hunting beat times out
    set_cfg(8'hFF, 8'h00, 8'd0);
    random_traffic(100);

    drain();
    set_cfg(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(254)));
    random_traffic(400);

    // No idling; long receiver hold-off so the buffer fills and the input stalls
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_cfg(CFG_W'($urandom), CFG_W'($urandom), 8'd20);
    hold_req = 1'b1;
    random_traffic(350);

    // Own and broadcast address equal
    drain();
    shared_addr = CFG_W'($urandom);
    set_cfg(shared_addr, shared_addr, CFG_W'($urandom_range(254, 16)));
    random_traffic(350);

    // Wait out the owed results, then wait on for anything stray
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d results never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("Sent %0d bits over %0d register settings; checked %0d result beats",
             sb.n_bits, settings_used, sb.n_results);
    $display("Seen: %0d frame ends, %0d commands out, %0d hunt timeouts, %0d saturated beats",
             sb.n_frame_ends, sb.n_commands, sb.n_timeouts, sb.n_saturated);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[powerline_frame_receiver.f]
rtl/pfr_pkg.sv
rtl/pfr_frame.sv
rtl/powerline_frame_receiver.sv
tb/sv/powerline_frame_receiver_tb.sv
